@@ rtl/pcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// pcsp_pkg
// Types, character constants and decode functions shared by the printf
// conversion specification parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pcsp_pkg;

	localparam int ACCUM_BITS_DEFAULT = 32;

	// Characters that the parser looks for.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LOW_L = 8'h6C;
	localparam logic [7:0] CH_UP_L  = 8'h4C;
	localparam logic [7:0] CH_LOW_H = 8'h68;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CH_LOW_J = 8'h6A;
	localparam logic [7:0] CH_LOW_D = 8'h64;
	localparam logic [7:0] CH_LOW_I = 8'h69;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LOW_U = 8'h75;
	localparam logic [7:0] CH_LOW_O = 8'h6F;
	localparam logic [7:0] CH_PCENT = 8'h25;
	localparam logic [7:0] CH_LOW_P = 8'h70;
	localparam logic [7:0] CH_LOW_S = 8'h73;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_C = 8'h63;
	localparam logic [7:0] CH_LOW_T = 8'h74;

	// Length modifier codes.
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_L    = 3'd1;
	localparam logic [2:0] LEN_UL   = 3'd2;
	localparam logic [2:0] LEN_H    = 3'd3;
	localparam logic [2:0] LEN_Z    = 3'd4;
	localparam logic [2:0] LEN_J    = 3'd5;
	localparam logic [2:0] LEN_LL   = 3'd6;
	localparam logic [2:0] LEN_HH   = 3'd7;

	// Conversion codes.
	localparam logic [3:0] SPEC_DI  = 4'd0;
	localparam logic [3:0] SPEC_B   = 4'd1;
	localparam logic [3:0] SPEC_X   = 4'd2;
	localparam logic [3:0] SPEC_UX  = 4'd3;
	localparam logic [3:0] SPEC_U   = 4'd4;
	localparam logic [3:0] SPEC_O   = 4'd5;
	localparam logic [3:0] SPEC_PCT = 4'd6;
	localparam logic [3:0] SPEC_P   = 4'd7;
	localparam logic [3:0] SPEC_S   = 4'd8;
	localparam logic [3:0] SPEC_F   = 4'd9;
	localparam logic [3:0] SPEC_C   = 4'd10;
	localparam logic [3:0] SPEC_T   = 4'd11;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef enum logic [2:0] {
		PH_FLAGS = 3'd0,
		PH_WDIG  = 3'd1,
		PH_WSTAR = 3'd2,
		PH_POPEN = 3'd3,
		PH_PDIG  = 3'd4,
		PH_LEN   = 3'd5,
		PH_LPEND = 3'd6,
		PH_SPEC  = 3'd7
	} pcsp_phase_t;

	typedef enum logic [3:0] {
		ACT_FLAG,
		ACT_WDIG,
		ACT_WSTAR,
		ACT_DOT,
		ACT_PSTAR,
		ACT_PDIG,
		ACT_LEN,
		ACT_DOUBLE,
		ACT_FINISH
	} pcsp_act_t;

	// Control part of the parser state; the accumulators travel separately
	// because their width follows the accumulator parameter.
	typedef struct packed {
		pcsp_phase_t phase;
		logic [4:0]  flags;
		logic [2:0]  length;
		logic [7:0]  count;
	} pcsp_ctl_t;

	localparam pcsp_ctl_t CTL_RESET = '{
		phase:  PH_FLAGS,
		flags:  5'd0,
		length: LEN_NONE,
		count:  8'd0
	};

	typedef struct packed {
		logic               valid_res;
		logic               left_justify;
		logic               zero_pad;
		logic               plus_sign;
		logic               space_sign;
		logic               alt_form;
		logic signed [31:0] min_width;
		logic signed [31:0] precision_value;
		logic [2:0]         length_code;
		logic [3:0]         spec_code;
		logic [7:0]         chars_used;
	} pcsp_res_t;

	function automatic logic [4:0] flag_mask(input logic [7:0] c);
		logic [4:0] m;
		m = 5'd0;
		unique case (c)
			CH_MINUS: m = 5'b00001;
			CH_ZERO:  m = 5'b00010;
			CH_PLUS:  m = 5'b00100;
			CH_SPACE: m = 5'b01000;
			CH_HASH:  m = 5'b10000;
			default:  m = 5'd0;
		endcase
		return m;
	endfunction

	function automatic logic [2:0] length_of(input logic [7:0] c);
		logic [2:0] l;
		l = LEN_NONE;
		unique case (c)
			CH_LOW_L: l = LEN_L;
			CH_UP_L:  l = LEN_UL;
			CH_LOW_H: l = LEN_H;
			CH_LOW_Z: l = LEN_Z;
			CH_LOW_J: l = LEN_J;
			default:  l = LEN_NONE;
		endcase
		return l;
	endfunction

	// Returns {known, code}.
	function automatic logic [4:0] spec_of(input logic [7:0] c);
		logic [4:0] s;
		s = {1'b0, SPEC_DI};
		unique case (c)
			CH_LOW_D, CH_LOW_I: s = {1'b1, SPEC_DI};
			CH_LOW_B: s = {1'b1, SPEC_B};
			CH_LOW_X: s = {1'b1, SPEC_X};
			CH_UP_X:  s = {1'b1, SPEC_UX};
			CH_LOW_U: s = {1'b1, SPEC_U};
			CH_LOW_O: s = {1'b1, SPEC_O};
			CH_PCENT: s = {1'b1, SPEC_PCT};
			CH_LOW_P: s = {1'b1, SPEC_P};
			CH_LOW_S: s = {1'b1, SPEC_S};
			CH_LOW_F: s = {1'b1, SPEC_F};
			CH_LOW_C: s = {1'b1, SPEC_C};
			CH_LOW_T: s = {1'b1, SPEC_T};
			default:  s = {1'b0, SPEC_DI};
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ rtl/pcsp_in_if.sv @@
// ----------------------------------------------------------------------------
// pcsp_in_if
// Character channel into the parser: one format character per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcsp_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         ch;
	logic               spec_start;
	logic signed [31:0] star_arg;

	modport source (output valid, ch, spec_start, star_arg, input ready);
	modport sink   (input valid, ch, spec_start, star_arg, output ready);
endinterface

`default_nettype wire

@@ rtl/pcsp_res_if.sv @@
// ----------------------------------------------------------------------------
// pcsp_res_if
// Result channel of the parser: one parsed conversion specification per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcsp_res_if;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic               left_justify;
	logic               zero_pad;
	logic               plus_sign;
	logic               space_sign;
	logic               alt_form;
	logic signed [31:0] min_width;
	logic signed [31:0] precision_value;
	logic [2:0]         length_code;
	logic [3:0]         spec_code;
	logic [7:0]         chars_used;

	modport source (
		output valid, valid_res, left_justify, zero_pad, plus_sign, space_sign,
			alt_form, min_width, precision_value, length_code, spec_code,
			chars_used,
		input ready
	);
	modport sink (
		input valid, valid_res, left_justify, zero_pad, plus_sign, space_sign,
			alt_form, min_width, precision_value, length_code, spec_code,
			chars_used,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/pcsp_step.sv @@
// ----------------------------------------------------------------------------
// pcsp_step
// One parsing step: from the current state and one character, the next
// state and, when the specification ends, its result.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsp_step import pcsp_pkg::*; #(
	parameter int ACCUM_BITS = ACCUM_BITS_DEFAULT,
	localparam int W = (ACCUM_BITS > 32) ? ACCUM_BITS : 32
) (
	input  pcsp_ctl_t          ctl_cur,
	input  logic [W-1:0]       width_cur,
	input  logic [W-1:0]       prec_cur,
	input  logic [7:0]         ch,
	input  logic               spec_start,
	input  logic signed [31:0] star_arg,
	output pcsp_ctl_t          ctl_nxt,
	output logic [W-1:0]       width_nxt,
	output logic [W-1:0]       prec_nxt,
	output logic               emit,
	output pcsp_res_t          res
);

	localparam logic [ACCUM_BITS-1:0] LIM = {1'b0, {(ACCUM_BITS-1){1'b1}}};

	pcsp_ctl_t              ctl_eff;
	logic [W-1:0]           width_eff;
	logic [W-1:0]           prec_eff;
	logic                   is_flag;
	logic                   is_digit;
	logic                   is_star;
	logic                   is_dot;
	logic [2:0]             len_code;
	logic [4:0]             spec_dec;
	logic                   spec_ok;
	pcsp_act_t              act;
	pcsp_act_t              los_act;
	pcsp_phase_t            phase_nxt;
	logic [ACCUM_BITS-1:0]  acc_base;
	logic [ACCUM_BITS+3:0]  acc_prod;
	logic [W-1:0]           acc_new;
	logic [W-1:0]           star_ext;
	logic [7:0]             count_inc;

	// A new specification abandons whatever was under way.
	assign ctl_eff   = spec_start ? CTL_RESET : ctl_cur;
	assign width_eff = spec_start ? '0 : width_cur;
	assign prec_eff  = spec_start ? '1 : prec_cur;

	assign is_flag  = (flag_mask(ch) != 5'd0);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_star  = (ch == CH_STAR);
	assign is_dot   = (ch == CH_DOT);
	assign len_code = length_of(ch);
	assign spec_dec = spec_of(ch);
	assign spec_ok  = spec_dec[4];
	assign los_act  = (len_code != LEN_NONE) ? ACT_LEN : ACT_FINISH;

	always_comb begin
		act = ACT_FINISH;
		unique case (ctl_eff.phase)
			PH_FLAGS: begin
				priority if (is_flag) act = ACT_FLAG;
				else if (is_digit)    act = ACT_WDIG;
				else if (is_star)     act = ACT_WSTAR;
				else if (is_dot)      act = ACT_DOT;
				else                  act = los_act;
			end
			PH_WDIG: begin
				priority if (is_digit) act = ACT_WDIG;
				else if (is_dot)       act = ACT_DOT;
				else                   act = los_act;
			end
			PH_WSTAR: act = is_dot ? ACT_DOT : los_act;
			PH_POPEN: begin
				priority if (is_star) act = ACT_PSTAR;
				else if (is_digit)    act = ACT_PDIG;
				else                  act = los_act;
			end
			PH_PDIG:  act = is_digit ? ACT_PDIG : los_act;
			PH_LEN:   act = los_act;
			PH_LPEND: begin
				if ((ctl_eff.length == LEN_L && ch == CH_LOW_L) ||
						(ctl_eff.length == LEN_H && ch == CH_LOW_H)) begin
					act = ACT_DOUBLE;
				end else begin
					act = ACT_FINISH;
				end
			end
			PH_SPEC:  act = ACT_FINISH;
			default:  act = ACT_FINISH;
		endcase
	end

	// Next phase.
	always_comb begin
		phase_nxt = PH_FLAGS;
		unique case (act)
			ACT_FLAG:   phase_nxt = PH_FLAGS;
			ACT_WDIG:   phase_nxt = PH_WDIG;
			ACT_WSTAR:  phase_nxt = PH_WSTAR;
			ACT_DOT:    phase_nxt = PH_POPEN;
			ACT_PSTAR:  phase_nxt = PH_LEN;
			ACT_PDIG:   phase_nxt = PH_PDIG;
			ACT_LEN:    phase_nxt = (len_code == LEN_L || len_code == LEN_H) ?
				PH_LPEND : PH_SPEC;
			ACT_DOUBLE: phase_nxt = PH_SPEC;
			ACT_FINISH: phase_nxt = PH_FLAGS;
			default:    phase_nxt = PH_FLAGS;
		endcase
	end

	// Decimal accumulation, shared by width and precision digits. The value
	// stays within the limit, so its low ACCUM_BITS bits hold it whole.
	assign acc_base = (act == ACT_WDIG) ? width_eff[ACCUM_BITS-1:0] :
		prec_eff[ACCUM_BITS-1:0];
	assign acc_prod = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1) +
		(ACCUM_BITS+4)'(ch[3:0]);
	assign acc_new  = W'((acc_prod > {4'd0, LIM}) ? LIM : acc_prod[ACCUM_BITS-1:0]);
	assign star_ext = W'(star_arg);

	assign count_inc = (ctl_eff.count != COUNT_MAX) ? ctl_eff.count + 8'd1 : COUNT_MAX;

	// Data part of the state and the result.
	always_comb begin
		ctl_nxt.phase  = phase_nxt;
		ctl_nxt.flags  = ctl_eff.flags;
		ctl_nxt.length = ctl_eff.length;
		ctl_nxt.count  = count_inc;
		width_nxt      = width_eff;
		prec_nxt       = prec_eff;
		emit           = 1'b0;
		unique case (act)
			ACT_FLAG:   ctl_nxt.flags = ctl_eff.flags | flag_mask(ch);
			ACT_WDIG:   width_nxt = acc_new;
			ACT_WSTAR:  width_nxt = star_ext;
			ACT_DOT:    prec_nxt = '0;
			ACT_PSTAR:  prec_nxt = star_ext;
			ACT_PDIG:   prec_nxt = acc_new;
			ACT_LEN:    ctl_nxt.length = len_code;
			ACT_DOUBLE: ctl_nxt.length = (ctl_eff.length == LEN_L) ? LEN_LL : LEN_HH;
			ACT_FINISH: begin
				ctl_nxt.flags  = 5'd0;
				ctl_nxt.length = LEN_NONE;
				ctl_nxt.count  = 8'd0;
				width_nxt      = '0;
				prec_nxt       = '1;
				emit           = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.valid_res       = spec_ok;
		res.left_justify    = ctl_eff.flags[0];
		res.zero_pad        = ctl_eff.flags[1];
		res.plus_sign       = ctl_eff.flags[2];
		res.space_sign      = ctl_eff.flags[3];
		res.alt_form        = ctl_eff.flags[4];
		res.min_width       = width_eff[31:0];
		res.precision_value = prec_eff[31:0];
		res.length_code     = ctl_eff.length;
		res.spec_code       = spec_ok ? spec_dec[3:0] : SPEC_DI;
		// The conversion letter itself counts only when it is a known one.
		res.chars_used      = spec_ok ? count_inc : ctl_eff.count;
	end

endmodule

`default_nettype wire

@@ rtl/pcsp_out_reg.sv @@
// ----------------------------------------------------------------------------
// pcsp_out_reg
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcsp_out_reg import pcsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  pcsp_res_t   res_in,
	output logic        can_load,
	pcsp_res_if.source  res_out
);

	logic      valid_q;
	pcsp_res_t res_q;

	assign can_load = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res_in;
		end
	end

	assign res_out.valid           = valid_q;
	assign res_out.valid_res       = res_q.valid_res;
	assign res_out.left_justify    = res_q.left_justify;
	assign res_out.zero_pad        = res_q.zero_pad;
	assign res_out.plus_sign       = res_q.plus_sign;
	assign res_out.space_sign      = res_q.space_sign;
	assign res_out.alt_form        = res_q.alt_form;
	assign res_out.min_width       = res_q.min_width;
	assign res_out.precision_value = res_q.precision_value;
	assign res_out.length_code     = res_q.length_code;
	assign res_out.spec_code       = res_q.spec_code;
	assign res_out.chars_used      = res_q.chars_used;

endmodule

`default_nettype wire

@@ rtl/printf_conversion_spec_parser_unit.sv @@
// ----------------------------------------------------------------------------
// printf_conversion_spec_parser_unit
// Parses one printf conversion specification from the characters after '%'.
// ----------------------------------------------------------------------------
// Usage:
//   spec_in carries one character per item, with spec_start set on the first
//   character of a specification and star_arg used when the character is '*'.
//   spec_out carries one item per finished specification: the flags, width,
//   precision, length and conversion codes, or valid_res low when an
//   unexpected character ended it. Characters that do not end a
//   specification give no result item.
//   An accepted character is registered in the input register, parsed
//   against the current state and, if it ends a specification, registered
//   in the result register that drives spec_out.
//   Throughput: one character per cycle unless an ending character waits on
//   a stalled receiver; the parse step shares its multiply-by-ten accumulator.
//   Reset clears the parser to the start of a specification and empties both
//   registers. When the receiver stalls, the result register holds; the
//   input register still drains characters that give no result, and only a
//   character that ends a specification waits, stalling spec_in behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module printf_conversion_spec_parser_unit import pcsp_pkg::*; #(
	parameter int ACCUM_BITS = ACCUM_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	pcsp_in_if.sink    spec_in,
	pcsp_res_if.source spec_out
);

	localparam int W = (ACCUM_BITS > 32) ? ACCUM_BITS : 32;

	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic               start_s1;
	logic signed [31:0] star_s1;

	pcsp_ctl_t    ctl_q;
	logic [W-1:0] width_q;
	logic [W-1:0] prec_q;

	pcsp_ctl_t    ctl_nxt;
	logic [W-1:0] width_nxt;
	logic [W-1:0] prec_nxt;
	logic         emit;
	pcsp_res_t    res;
	logic         can_load;
	logic         advance;

	assign advance       = valid_s1 && (!emit || can_load);
	assign spec_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (spec_in.ready) begin
			valid_s1 <= spec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (spec_in.valid && spec_in.ready) begin
			ch_s1    <= spec_in.ch;
			start_s1 <= spec_in.spec_start;
			star_s1  <= spec_in.star_arg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= CTL_RESET;
			width_q <= '0;
			prec_q  <= '1;
		end else if (advance) begin
			ctl_q   <= ctl_nxt;
			width_q <= width_nxt;
			prec_q  <= prec_nxt;
		end
	end

	pcsp_step #(
		.ACCUM_BITS (ACCUM_BITS)
	) u_step (
		.ctl_cur    (ctl_q),
		.width_cur  (width_q),
		.prec_cur   (prec_q),
		.ch         (ch_s1),
		.spec_start (start_s1),
		.star_arg   (star_s1),
		.ctl_nxt    (ctl_nxt),
		.width_nxt  (width_nxt),
		.prec_nxt   (prec_nxt),
		.emit       (emit),
		.res        (res)
	);

	pcsp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.res_in   (res),
		.can_load (can_load),
		.res_out  (spec_out)
	);

	// Once a specification has ended, parsing starts afresh.
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (ctl_q.phase == PH_FLAGS && ctl_q.count == 8'd0))
		else $error("parser state not cleared after a result");

	// Past the flags phase at least one character has been consumed.
	a_count_past_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.phase != PH_FLAGS) |-> (ctl_q.count != 8'd0))
		else $error("character count is zero outside the flags phase");

	// Only a single l or h can wait for its second letter.
	a_pending_length: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.phase == PH_LPEND) |-> (ctl_q.length == LEN_L || ctl_q.length == LEN_H))
		else $error("pending length phase without l or h");

	// A character that is held back must stay in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(ch_s1) && $stable(start_s1)))
		else $error("stalled character lost from the input register");

	// An invalid result carries the default conversion code.
	a_invalid_code: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && !res.valid_res) |-> (res.spec_code == SPEC_DI))
		else $error("invalid result with a conversion code");

endmodule

`default_nettype wire
